// ===== sv/lpcd_pkg.sv =====
// Shared types, constants and the sensor weight table for the line position
// and corner detector. Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package lpcd_pkg;

  // Defaults for the top-level parameters.
  localparam int SAMPLE_BITS_DEF        = 12;
  localparam int POSITION_FRAC_BITS_DEF = 4;

  // Fixed geometry of the sensor bar.
  localparam int NUM_SENSORS = 8;
  localparam int NUM_LEFT    = 4;
  localparam int CORNER_MIN  = 3;

  // Field widths.
  localparam int THRESH_W = 12;
  localparam int COUNT_W  = 4;
  localparam int POS_W    = 10;
  localparam int TOTAL_W  = 32;
  localparam int WEIGHT_W = 7;
  localparam int SUM_W    = 8;   // sum of weights stays within -78..78
  localparam int ABS_W    = 7;   // magnitude of that sum

  localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd2048;

  // Queue between classifier and divider; a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One classified scan as it waits in the queue.
  typedef struct packed {
    logic [NUM_SENSORS-1:0]  mask;
    logic [COUNT_W-1:0]      count;
    logic signed [SUM_W-1:0] sum;
    logic                    corner;
  } scan_t;

  // Signed weight of each sensor, leftmost first.
  function automatic logic signed [WEIGHT_W-1:0] weight(input logic [2:0] idx);
    logic signed [WEIGHT_W-1:0] w;
    case (idx)
      3'd0:    w = -7'sd30;
      3'd1:    w = -7'sd22;
      3'd2:    w = -7'sd16;
      3'd3:    w = -7'sd10;
      3'd4:    w = 7'sd10;
      3'd5:    w = 7'sd16;
      3'd6:    w = 7'sd22;
      3'd7:    w = 7'sd30;
      default: w = 7'sd0;
    endcase
    return w;
  endfunction

endpackage

// ===== sv/lpcd_front.sv =====
// Front end: holds the black threshold, accepts scans and classifies them
// into mask, count, weight sum and corner flag. Depends on lpcd_pkg.
`timescale 1ns / 1ps

module lpcd_front #(
  parameter int SAMPLE_BITS = lpcd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lpcd_pkg::THRESH_W-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [SAMPLE_BITS-1:0]        samples_i [lpcd_pkg::NUM_SENSORS],
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output lpcd_pkg::scan_t               q_entry_o
);

  localparam int CMP_W = (SAMPLE_BITS > lpcd_pkg::THRESH_W) ? SAMPLE_BITS
                                                             : lpcd_pkg::THRESH_W;

  logic [lpcd_pkg::THRESH_W-1:0] thresh_q;

  // Threshold; user must write it only while the block is idle; not enforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= lpcd_pkg::THRESH_RESET;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  // Classify the scan: black sensors, their count, weight sum and left count.
  always_comb begin
    logic [lpcd_pkg::NUM_SENSORS-1:0]  mask;
    logic [lpcd_pkg::COUNT_W-1:0]      count;
    logic signed [lpcd_pkg::SUM_W-1:0] sum;
    logic [2:0]                        left;
    mask  = '0;
    count = '0;
    sum   = '0;
    left  = '0;
    for (int i = 0; i < lpcd_pkg::NUM_SENSORS; i++) begin
      if (CMP_W'(samples_i[i]) > CMP_W'(thresh_q)) begin
        mask[i] = 1'b1;
        count   = count + 1'b1;
        sum     = sum + lpcd_pkg::SUM_W'(lpcd_pkg::weight(3'(i)));
        if (i < lpcd_pkg::NUM_LEFT) begin
          left = left + 1'b1;
        end
      end
    end
    q_entry_o.mask   = mask;
    q_entry_o.count  = count;
    q_entry_o.sum    = sum;
    q_entry_o.corner = (left >= 3'(lpcd_pkg::CORNER_MIN));
  end

  // A beat is taken whenever the queue has room.
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule

// ===== sv/lpcd_queue.sv =====
// Short queue of classified scans between the front end and the divider.
// Depends on lpcd_pkg for the entry type and depth.
`timescale 1ns / 1ps

module lpcd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lpcd_pkg::scan_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output lpcd_pkg::scan_t entry_o,
  output logic            empty_o
);

  lpcd_pkg::scan_t                 mem_q [lpcd_pkg::QUEUE_DEPTH];
  logic [lpcd_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [lpcd_pkg::QPTR_W:0]       fill_q;

  assign full_o  = (fill_q == (lpcd_pkg::QPTR_W+1)'(lpcd_pkg::QUEUE_DEPTH));
  assign empty_o = (fill_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  // Storage, written at the tail.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

// ===== sv/lpcd_back.sv =====
// Back end: takes scans from the queue, tracks corner edges, divides the
// scaled weight sum by the black count one bit a cycle and presents the
// result beat. Depends on lpcd_pkg.
`timescale 1ns / 1ps

module lpcd_back #(
  parameter int POSITION_FRAC_BITS = lpcd_pkg::POSITION_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_empty_i,
  input  lpcd_pkg::scan_t                     q_entry_i,
  output logic                                q_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [lpcd_pkg::POS_W-1:0]   position_o,
  output logic [lpcd_pkg::NUM_SENSORS-1:0]    black_mask_o,
  output logic [lpcd_pkg::COUNT_W-1:0]        black_count_o,
  output logic                                corner_now_o,
  output logic                                corner_rise_o,
  output logic [lpcd_pkg::TOTAL_W-1:0]        corner_total_o
);

  localparam int MAG_W  = lpcd_pkg::ABS_W + POSITION_FRAC_BITS;
  localparam int RES_W  = (MAG_W + 1 > lpcd_pkg::POS_W) ? MAG_W + 1 : lpcd_pkg::POS_W;
  localparam int STEP_W = $clog2(MAG_W);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  state_e                               state_q;
  logic [STEP_W-1:0]                    step_q;
  logic [MAG_W-1:0]                     quo_q, quo_d;
  logic [lpcd_pkg::COUNT_W-1:0]         rem_q, rem_d;
  logic [lpcd_pkg::COUNT_W-1:0]         div_q;
  logic                                 neg_q;
  logic signed [lpcd_pkg::POS_W-1:0]    held_q;
  logic                                 prev_corner_q;
  logic [lpcd_pkg::TOTAL_W-1:0]         events_q;
  logic                                 rise_q;
  logic [lpcd_pkg::NUM_SENSORS-1:0]     mask_q;
  logic [lpcd_pkg::COUNT_W-1:0]         count_q;
  logic [MAG_W-1:0]                     load_mag;
  logic [lpcd_pkg::SUM_W-1:0]           abs_sum;
  logic                                 rise_now;
  logic [lpcd_pkg::POS_W-1:0]           pos_d;

  assign q_pop_o  = (state_q == ST_IDLE) && !q_empty_i;
  assign rise_now = q_entry_i.corner && !prev_corner_q;

  // Magnitude of the weight sum, scaled by the fraction bits.
  assign abs_sum  = q_entry_i.sum[lpcd_pkg::SUM_W-1] ? -q_entry_i.sum : q_entry_i.sum;
  assign load_mag = MAG_W'(abs_sum[lpcd_pkg::ABS_W-1:0]) << POSITION_FRAC_BITS;

  // One restoring divide step, and the signed quotient cut to the field.
  always_comb begin
    logic [lpcd_pkg::COUNT_W:0] trial;
    logic                       ge;
    logic [RES_W-1:0]           qext;
    trial = {rem_q, quo_q[MAG_W-1]};
    ge    = (trial >= {1'b0, div_q});
    rem_d = ge ? lpcd_pkg::COUNT_W'(trial - {1'b0, div_q})
               : lpcd_pkg::COUNT_W'(trial);
    quo_d = {quo_q[MAG_W-2:0], ge};
    qext  = RES_W'(quo_d);
    qext  = neg_q ? -qext : qext;
    pos_d = qext[lpcd_pkg::POS_W-1:0];
  end

  // Sequencer: take a scan, divide if anything is black, hold the result beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      held_q        <= '0;
      prev_corner_q <= 1'b0;
      events_q      <= '0;
      step_q        <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            prev_corner_q <= q_entry_i.corner;
            if (rise_now) begin
              events_q <= events_q + 1'b1;
            end
            step_q  <= STEP_W'(MAG_W - 1);
            state_q <= (q_entry_i.count == '0) ? ST_OUT : ST_DIV;
          end
        end
        ST_DIV: begin
          if (step_q == '0) begin
            held_q  <= pos_d;
            state_q <= ST_OUT;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        ST_OUT: begin
          if (!out_stall_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Divider datapath and result payload.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      quo_q   <= load_mag;
      rem_q   <= '0;
      div_q   <= q_entry_i.count;
      neg_q   <= q_entry_i.sum[lpcd_pkg::SUM_W-1];
      mask_q  <= q_entry_i.mask;
      count_q <= q_entry_i.count;
      rise_q  <= rise_now;
    end else if (state_q == ST_DIV) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign out_valid_o    = (state_q == ST_OUT);
  assign position_o     = held_q;
  assign black_mask_o   = mask_q;
  assign black_count_o  = count_q;
  assign corner_now_o   = prev_corner_q;
  assign corner_rise_o  = rise_q;
  assign corner_total_o = events_q;

endmodule

// ===== sv/line_position_corner_detector_core.sv =====
// Top level of the line position and corner detector: front classifier,
// scan queue and divider back end. Depends on lpcd_pkg, lpcd_front,
// lpcd_queue and lpcd_back.
//
//   Channel  Handshake                Payload
//   -------  -----------------------  ------------------------------------------
//   config   cfg_we_i                 cfg_wdata_i (black threshold)
//   scan in  in_valid_i / in_stall_o  sample_0_i .. sample_7_i
//   result   out_valid_o / out_stall_i position_o, black_mask_o, black_count_o,
//                                     corner_now_o, corner_rise_o, corner_total_o
//
// A scan with a black sensor runs the back end through idle, divide and output,
// the divide by the black count taking one bit a cycle; an all-white scan goes
// from idle straight to output. The front end takes a beat every cycle while the
// two-entry queue has room. Reset is asynchronous and clears the threshold to
// 2048 and the held position and corner counter to zero. A stalled result holds
// the back end; the queue keeps taking scans until it fills.
`timescale 1ns / 1ps

module line_position_corner_detector_core #(
  parameter int SAMPLE_BITS        = lpcd_pkg::SAMPLE_BITS_DEF,
  parameter int POSITION_FRAC_BITS = lpcd_pkg::POSITION_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lpcd_pkg::THRESH_W-1:0]     cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [SAMPLE_BITS-1:0]            sample_0_i,
  input  logic [SAMPLE_BITS-1:0]            sample_1_i,
  input  logic [SAMPLE_BITS-1:0]            sample_2_i,
  input  logic [SAMPLE_BITS-1:0]            sample_3_i,
  input  logic [SAMPLE_BITS-1:0]            sample_4_i,
  input  logic [SAMPLE_BITS-1:0]            sample_5_i,
  input  logic [SAMPLE_BITS-1:0]            sample_6_i,
  input  logic [SAMPLE_BITS-1:0]            sample_7_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [lpcd_pkg::POS_W-1:0] position_o,
  output logic [lpcd_pkg::NUM_SENSORS-1:0]  black_mask_o,
  output logic [lpcd_pkg::COUNT_W-1:0]      black_count_o,
  output logic                              corner_now_o,
  output logic                              corner_rise_o,
  output logic [lpcd_pkg::TOTAL_W-1:0]      corner_total_o
);

  logic [SAMPLE_BITS-1:0] samples [lpcd_pkg::NUM_SENSORS];
  logic                   q_full, q_push, q_pop, q_empty;
  lpcd_pkg::scan_t        push_entry, head_entry;

  // Gather the sample ports, leftmost first.
  assign samples[0] = sample_0_i;
  assign samples[1] = sample_1_i;
  assign samples[2] = sample_2_i;
  assign samples[3] = sample_3_i;
  assign samples[4] = sample_4_i;
  assign samples[5] = sample_5_i;
  assign samples[6] = sample_6_i;
  assign samples[7] = sample_7_i;

  lpcd_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .samples_i  (samples),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (push_entry)
  );

  lpcd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(push_entry),
    .full_o (q_full),
    .pop_i  (q_pop),
    .entry_o(head_entry),
    .empty_o(q_empty)
  );

  lpcd_back #(
    .POSITION_FRAC_BITS(POSITION_FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_entry_i     (head_entry),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .position_o    (position_o),
    .black_mask_o  (black_mask_o),
    .black_count_o (black_count_o),
    .corner_now_o  (corner_now_o),
    .corner_rise_o (corner_rise_o),
    .corner_total_o(corner_total_o)
  );

endmodule

// ===== bench/line_position_corner_detector_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for line_position_corner_detector_core: directed and random sensor
// scans, each result beat checked against a behavioral line-position predictor.
// Depends on lpcd_pkg and the RTL of the block.

module line_position_corner_detector_core_test;
  import lpcd_pkg::*;

  localparam int SAMPLE_W        = SAMPLE_BITS_DEF;
  localparam int SAMPLE_MAX      = (1 << SAMPLE_W) - 1;
  localparam int THRESH_MAX      = (1 << THRESH_W) - 1;
  localparam int CORNER_LEFT_MIN = 3;
  localparam int FRAC_SCALE      = 1 << POSITION_FRAC_BITS_DEF;
  localparam int IDLE_LIMIT      = 3000;
  localparam int TAIL_CYCLES     = 40;
  localparam int MAX_REPORTS     = 10;
  localparam int MODE_PERIOD     = 80;

  typedef enum logic [1:0] {OP_SCAN, OP_CFG, OP_DRAIN} op_kind_e;

  typedef logic [NUM_SENSORS-1:0][SAMPLE_W-1:0] scan_samples_t;

  // One entry of the stimulus list: a scan, a threshold write or a drain pause.
  typedef struct packed {
    op_kind_e            kind;
    logic [THRESH_W-1:0] thr;
    scan_samples_t       smp;
  } pending_op_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic [NUM_SENSORS-1:0]  mask;
    logic [COUNT_W-1:0]      count;
    logic                    corner_now;
    logic                    corner_rise;
    logic [TOTAL_W-1:0]      total;
  } scan_result_t;

  // Clock, reset and the bench-driven inputs, all known from time zero.
  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we     = 1'b0;
  logic [THRESH_W-1:0] cfg_wdata  = '0;
  logic                in_valid   = 1'b0;
  scan_samples_t       tx_samples = '0;
  logic                out_stall  = 1'b0;

  logic                    in_stall;
  logic                    out_valid;
  logic signed [POS_W-1:0] position_w;
  logic [NUM_SENSORS-1:0]  mask_w;
  logic [COUNT_W-1:0]      count_w;
  logic                    corner_now_w;
  logic                    corner_rise_w;
  logic [TOTAL_W-1:0]      total_w;

  // Stimulus list and the results still owed by the block.
  pending_op_t  pending_q[$];
  scan_result_t line_result_q[$];

  // Predictor state.
  logic [THRESH_W-1:0]     model_thr;
  logic signed [POS_W-1:0] model_held_pos;
  logic                    model_prev_corner;
  logic [TOTAL_W-1:0]      model_corner_total;
  int                      line_weight [NUM_SENSORS] = '{-30, -22, -16, -10, 10, 16, 22, 30};

  int          scans_sent   = 0;
  int          results_seen = 0;
  int          fail_count   = 0;
  int          cfg_writes   = 0;
  int          rises_seen   = 0;
  int          dark_scans   = 0;
  int          idle_cycles  = 0;
  int unsigned send_gap     = 0;
  int unsigned stall_left   = 0;
  logic        send_burst   = 1'b0;
  logic        recv_burst   = 1'b0;

  line_position_corner_detector_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .sample_0_i     (tx_samples[0]),
    .sample_1_i     (tx_samples[1]),
    .sample_2_i     (tx_samples[2]),
    .sample_3_i     (tx_samples[3]),
    .sample_4_i     (tx_samples[4]),
    .sample_5_i     (tx_samples[5]),
    .sample_6_i     (tx_samples[6]),
    .sample_7_i     (tx_samples[7]),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .position_o     (position_w),
    .black_mask_o   (mask_w),
    .black_count_o  (count_w),
    .corner_now_o   (corner_now_w),
    .corner_rise_o  (corner_rise_w),
    .corner_total_o (total_w)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Classifies one scan, updates the held position and corner state, returns the result.
  function automatic scan_result_t predict_scan(scan_samples_t smp);
    scan_result_t r;
    int           sum;
    int           left;
    int           cnt;
    int           quot;
    r    = '0;
    sum  = 0;
    left = 0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (smp[i] > model_thr) begin
        r.mask[i] = 1'b1;
        r.count   = r.count + 1'b1;
        sum       = sum + line_weight[i];
        if (i < NUM_LEFT) left++;
      end
    end
    r.corner_now = (left >= CORNER_LEFT_MIN);
    if (r.corner_now && !model_prev_corner) begin
      r.corner_rise      = 1'b1;
      model_corner_total = model_corner_total + 1'b1;
      rises_seen++;
    end
    model_prev_corner = r.corner_now;
    // Signed division truncates toward zero; only the low field bits are kept.
    cnt = r.count;
    if (cnt != 0) begin
      quot           = (sum * FRAC_SCALE) / cnt;
      model_held_pos = quot[POS_W-1:0];
    end else begin
      dark_scans++;
    end
    r.position = model_held_pos;
    r.total    = model_corner_total;
    return r;
  endfunction

  // Pause length: mostly none or short, now and then long.
  function automatic int unsigned pick_pause(logic burst);
    int unsigned r;
    r = $urandom_range(99, 0);
    if (burst || r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 12);
  endfunction

  function automatic scan_samples_t scan_from_mask(logic [NUM_SENSORS-1:0] m,
                                                   int unsigned hi, int unsigned lo);
    scan_samples_t s;
    for (int i = 0; i < NUM_SENSORS; i++) s[i] = m[i] ? SAMPLE_W'(hi) : SAMPLE_W'(lo);
    return s;
  endfunction

  // A sample on the requested side of the threshold, often right at the boundary.
  function automatic logic [SAMPLE_W-1:0] sample_for(int unsigned thr, logic black);
    int unsigned v;
    if (black && thr < SAMPLE_MAX)
      v = ($urandom_range(3, 0) == 0) ? thr + 1 : $urandom_range(SAMPLE_MAX, thr + 1);
    else if (black)
      v = SAMPLE_MAX;
    else
      v = ($urandom_range(3, 0) == 0) ? thr : $urandom_range(thr, 0);
    return SAMPLE_W'(v);
  endfunction

  // Mostly line-shaped scans (a narrow stripe or a corner), some pure noise.
  function automatic scan_samples_t random_scan(int unsigned thr);
    scan_samples_t          s;
    logic [NUM_SENSORS-1:0] m;
    int unsigned            pick;
    int unsigned            w;
    pick = $urandom_range(9, 0);
    w    = $urandom_range(3, 1);
    case (pick)
      3, 4, 5, 6: m = NUM_SENSORS'(((1 << w) - 1) << $urandom_range(NUM_SENSORS - w, 0));
      7, 8:       m = {4'($urandom_range(15, 0)), 4'hF & ~(4'h1 << $urandom_range(4, 0))};
      default:    m = '0;
    endcase
    for (int i = 0; i < NUM_SENSORS; i++)
      s[i] = (pick < 3) ? SAMPLE_W'($urandom_range(SAMPLE_MAX, 0)) : sample_for(thr, m[i]);
    return s;
  endfunction

  task automatic queue_scan(input scan_samples_t s);
    pending_op_t op;
    op      = '0;
    op.kind = OP_SCAN;
    op.smp  = s;
    pending_q.push_back(op);
  endtask

  task automatic queue_ctl(input op_kind_e k, input int unsigned thr);
    pending_op_t op;
    op      = '0;
    op.kind = k;
    op.thr  = THRESH_W'(thr);
    pending_q.push_back(op);
  endtask

  // Driver: presents scans from the list; writes and drain pauses wait for an idle block.
  always @(posedge clk_i or negedge rst_ni) begin : scan_driver
    logic                go_valid;
    logic                go_we;
    logic [THRESH_W-1:0] go_wdata;
    scan_samples_t       go_smp;
    pending_op_t         head;
    go_valid = in_valid;
    go_we    = 1'b0;
    go_wdata = cfg_wdata;
    go_smp   = tx_samples;
    if (!rst_ni) begin
      in_valid           <= 1'b0;
      cfg_we             <= 1'b0;
      scans_sent         <= 0;
      model_thr          = THRESH_RESET;
      model_held_pos     = '0;
      model_prev_corner  = 1'b0;
      model_corner_total = '0;
    end else begin
      if (in_valid) begin
        // A beat is taken when the block does not stall it.
        if (!in_stall) begin
          line_result_q.push_back(predict_scan(tx_samples));
          scans_sent <= scans_sent + 1;
          if ((scans_sent + 1) % MODE_PERIOD == 0) send_burst = ($urandom_range(3, 0) == 0);
          send_gap = pick_pause(send_burst);
          go_valid = 1'b0;
          if (send_gap == 0 && pending_q.size() != 0 && pending_q[0].kind == OP_SCAN) begin
            head     = pending_q.pop_front();
            go_valid = 1'b1;
            go_smp   = head.smp;
          end
        end
      end else if (send_gap != 0) begin
        send_gap--;
      end else if (pending_q.size() != 0) begin
        head = pending_q[0];
        case (head.kind)
          OP_SCAN: begin
            void'(pending_q.pop_front());
            go_valid = 1'b1;
            go_smp   = head.smp;
          end
          OP_CFG: begin
            if (scans_sent == results_seen) begin
              void'(pending_q.pop_front());
              go_we     = 1'b1;
              go_wdata  = head.thr;
              model_thr = head.thr;
              cfg_writes++;
            end
          end
          default: begin
            if (scans_sent == results_seen) void'(pending_q.pop_front());
          end
        endcase
      end
      in_valid   <= go_valid;
      cfg_we     <= go_we;
      cfg_wdata  <= go_wdata;
      tx_samples <= go_smp;
    end
  end

  // Monitor: checks every result beat against the oldest prediction and drives stall.
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    scan_result_t got;
    scan_result_t want;
    logic         go_stall;
    logic         bad;
    go_stall = 1'b0;
    if (!rst_ni) begin
      out_stall    <= 1'b0;
      results_seen <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.position    = position_w;
        got.mask        = mask_w;
        got.count       = count_w;
        got.corner_now  = corner_now_w;
        got.corner_rise = corner_rise_w;
        got.total       = total_w;
        results_seen <= results_seen + 1;
        if ((results_seen + 1) % MODE_PERIOD == 0) recv_burst = ($urandom_range(3, 0) == 0);
        if (line_result_q.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("[%0t] result beat with no scan waiting for it", $time);
          fail_count++;
        end else begin
          want = line_result_q.pop_front();
          bad  = (got.position !== want.position) || (got.mask !== want.mask) ||
                 (got.count !== want.count) || (got.corner_now !== want.corner_now) ||
                 (got.corner_rise !== want.corner_rise) || (got.total !== want.total);
          if (bad) begin
            if (fail_count < MAX_REPORTS) begin
              $display("[%0t] result %0d mismatch: exp pos %0d mask %02h cnt %0d now %0b rise %0b tot %0d",
                       $time, results_seen, $signed(want.position), want.mask, want.count,
                       want.corner_now, want.corner_rise, want.total);
              $display("    got pos %0d mask %02h cnt %0d now %0b rise %0b tot %0d",
                       $signed(got.position), got.mask, got.count, got.corner_now,
                       got.corner_rise, got.total);
            end
            fail_count++;
          end
        end
      end
      // Stall pattern runs on its own, independent of out_valid.
      if (stall_left != 0) begin
        stall_left--;
        go_stall = 1'b1;
      end else if (!recv_burst && $urandom_range(3, 0) == 0) begin
        stall_left = pick_pause(1'b0);
      end
      out_stall <= go_stall;
    end
  end

  // Watchdog: too long without any beat or write means the block is hung.
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("[%0t] no beat for %0d cycles", $time, IDLE_LIMIT);
      $display("FAIL line_position_corner_detector_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned thr;
    int unsigned n_items;
    int unsigned mid;
    mid = int'(THRESH_RESET);

    // Directed scans at the reset threshold.
    queue_scan(scan_from_mask(8'h00, 0, 0));
    for (int i = 0; i < NUM_SENSORS; i++)
      queue_scan(scan_from_mask(8'h01 << i, SAMPLE_MAX, 0));
    // Three left sensors one above the threshold, the rest exactly at it.
    queue_scan(scan_from_mask(8'h07, mid + 1, mid));
    queue_scan(scan_from_mask(8'h07, mid + 1, mid));
    // Everything at the threshold counts as white, so the position is held.
    queue_scan(scan_from_mask(8'h00, mid, mid));
    queue_scan(scan_from_mask(8'hFF, SAMPLE_MAX, 0));
    queue_scan(scan_from_mask(8'h8F, SAMPLE_MAX, 0));
    queue_scan(scan_from_mask(8'hF0, SAMPLE_MAX, 0));
    queue_scan(scan_from_mask(8'h0B, SAMPLE_MAX, 0));

    // Lowest threshold: only a zero sample is white.
    queue_ctl(OP_CFG, 0);
    queue_scan(scan_from_mask(8'h00, 1, 0));
    queue_scan(scan_from_mask(8'hFF, 1, 0));
    queue_scan(scan_from_mask(8'h5A, 1, 0));
    // Highest threshold: nothing can be black.
    queue_ctl(OP_CFG, THRESH_MAX);
    queue_scan(scan_from_mask(8'hFF, SAMPLE_MAX, 0));
    queue_ctl(OP_CFG, THRESH_MAX - 1);
    queue_scan(scan_from_mask(8'hFF, SAMPLE_MAX, 0));
    queue_scan(scan_from_mask(8'h81, SAMPLE_MAX, THRESH_MAX - 1));

    // Random phases, each under its own threshold, with a drain pause midway.
    for (int p = 0; p < 9; p++) begin
      case (p)
        0:       thr = mid;
        1:       thr = 0;
        2:       thr = THRESH_MAX;
        3:       thr = 1;
        4:       thr = THRESH_MAX - 1;
        default: thr = $urandom_range(THRESH_MAX, 0);
      endcase
      n_items = (thr == THRESH_MAX) ? 40 : 145;
      queue_ctl(OP_CFG, thr);
      for (int k = 0; k < n_items; k++) begin
        if (k == n_items / 2) queue_ctl(OP_DRAIN, 0);
        queue_scan(random_scan(thr));
      end
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (pending_q.size() != 0 || in_valid || scans_sent != results_seen)
      @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (line_result_q.size() != 0)
      $display("%0d predicted results never arrived", line_result_q.size());
    fail_count = fail_count + line_result_q.size();

    $display("Ran %0d scans under %0d threshold settings, %0d result beats checked.",
             scans_sent, cfg_writes + 1, results_seen);
    $display("Predicted %0d corner rises and %0d scans with no sensor black.",
             rises_seen, dark_scans);
    if (fail_count == 0) begin
      $display("PASS line_position_corner_detector_core");
    end else begin
      $display("%0d failures", fail_count);
      $display("FAIL line_position_corner_detector_core");
    end
    $finish;
  end

endmodule
